>>> hw/rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// No dependencies; used by cau_div and complex_arithmetic_unit.
package cau_pkg;

  // quotient bits kept by the divider (bits 32 down to 0)
  localparam int unsigned QBITS = 33;
  // width of a product magnitude
  localparam int unsigned MW    = 64;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4
  } cmd_e;

  // per-item sideband carried alongside the divider lanes
  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic [MW-1:0] mag_re;   // numerator for divide, final magnitude otherwise
    logic [MW-1:0] mag_im;
  } side_t;

endpackage

>>> hw/rtl/cau_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on cau_pkg.
module cau_div import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  side_t             side_i,
  input  logic [MW-1:0]     den_i,
  output logic              valid_o,
  input  logic              ready_i,
  output side_t             side_o,
  output logic [QBITS-1:0]  q_re_o,
  output logic [QBITS-1:0]  q_im_o,
  output logic              big_re_o,
  output logic              big_im_o
);

  localparam int unsigned NW = MW + FRAC_BITS;  // width of the scaled numerator
  localparam int unsigned S  = QBITS + 1;       // range check stage plus one per bit
  localparam int unsigned RW = MW - 1;          // remainder stays below the divisor

  logic [S:0]           en;
  logic                 v_q    [S];
  side_t                side_q [S];
  logic [MW-1:0]        den_q  [S];
  logic [RW-1:0]        rem_q  [2][S];
  logic [QBITS-1:0]     lo_q   [2][S];
  logic [QBITS-1:0]     quo_q  [2][S];
  logic                 big_q  [2][S];

  // a stage moves when it is empty or its successor moves
  assign en[S]   = ready_i;
  assign ready_o = en[0];

  for (genvar s = 0; s < S; s++) begin : g_stage
    assign en[s] = !v_q[s] || en[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= (s == 0) ? valid_i : v_q[(s == 0) ? 0 : s-1];
      end
    end

    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[0]) begin
          side_q[0] <= side_i;
          den_q[0]  <= den_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          side_q[s] <= side_q[s-1];
          den_q[s]  <= den_q[s-1];
        end
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      if (s == 0) begin : g_pre
        // range check: quotient of 2^QBITS or more saturates anyway
        logic [MW-1:0]       num;
        logic [NW-1:0]       nsc;
        logic [NW-QBITS-1:0] hi;
        logic                big;
        assign num = (l == 0) ? side_i.mag_re : side_i.mag_im;
        assign nsc = NW'(num) << FRAC_BITS;
        assign hi  = nsc[NW-1:QBITS];
        assign big = MW'(hi) >= den_i;

        always_ff @(posedge clk_i) begin
          if (en[0]) begin
            big_q[l][0] <= big;
            rem_q[l][0] <= big ? '0 : RW'(hi);
            lo_q[l][0]  <= nsc[QBITS-1:0];
            quo_q[l][0] <= '0;
          end
        end
      end else begin : g_iter
        // shift in the next numerator bit, subtract the divisor if it fits
        logic [MW-1:0] r2;
        logic [MW-1:0] diff;
        logic          ge;
        assign r2   = {rem_q[l][s-1], lo_q[l][s-1][QBITS-1]};
        assign diff = r2 - den_q[s-1];
        assign ge   = r2 >= den_q[s-1];

        always_ff @(posedge clk_i) begin
          if (en[s]) begin
            big_q[l][s] <= big_q[l][s-1];
            rem_q[l][s] <= ge ? diff[RW-1:0] : r2[RW-1:0];
            lo_q[l][s]  <= {lo_q[l][s-1][QBITS-2:0], 1'b0};
            quo_q[l][s] <= {quo_q[l][s-1][QBITS-2:0], ge};
          end
        end
      end
    end
  end

  assign valid_o  = v_q[S-1];
  assign side_o   = side_q[S-1];
  assign q_re_o   = quo_q[0][S-1];
  assign q_im_o   = quo_q[1][S-1];
  assign big_re_o = big_q[0][S-1];
  assign big_im_o = big_q[1][S-1];

endmodule

>>> hw/rtl/complex_arithmetic_unit.sv
// Complex-number ALU on signed fixed point: add, subtract, multiply, divide, negate.
// Depends on cau_pkg and cau_div.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid_i / in_ready_o | cmd_i, x_re_i, x_im_i, y_re_i, y_im_i
//  out     | out_valid_o/ out_ready_i| res_re_o, res_im_o, overflow_o, div_zero_o
//
// One item per cycle sustained while out_ready_i stays high; stages: multiply, add, magnitude,
// 34 divider stages (range check plus one quotient bit each), output register.
// Every item, whatever its operation, passes the divider stages.
// Reset clears only the stage valid bits.
// Each stage advances when empty or when its successor advances, so bubbles
// are squeezed out and input is taken while a result waits at the output.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] x_re_i,
  input  logic signed [31:0] x_im_i,
  input  logic signed [31:0] y_re_i,
  input  logic signed [31:0] y_im_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic               overflow_o,
  output logic               div_zero_o
);

  // saturate a sign and magnitude to 32 bits: {overflow, value}
  function automatic logic [32:0] sat_fn(input logic neg, input logic [MW-1:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > MW'(64'h8000_0000)) r = {1'b1, 32'h8000_0000};
      else                          r = {1'b0, 32'(~mag + MW'(1))};
    end else begin
      if (mag > MW'(64'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
      else                          r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  logic en_a, en_b, en_c, en_o, div_ready;

  // stage A: operands and the six products
  logic               v_a_q;
  cmd_e               cmd_a_q;
  logic signed [31:0] xr_a_q, xi_a_q, yr_a_q, yi_a_q;
  logic signed [63:0] prr_q, pii_q, pri_q, pir_q, pyr_q, pyi_q;
  logic signed [63:0] prr_d, pii_d, pri_d, pir_d, pyr_d, pyi_d;

  assign prr_d = x_re_i * y_re_i;
  assign pii_d = x_im_i * y_im_i;
  assign pri_d = x_re_i * y_im_i;
  assign pir_d = x_im_i * y_re_i;
  assign pyr_d = y_re_i * y_re_i;
  assign pyi_d = y_im_i * y_im_i;

  assign en_a       = !v_a_q || en_b;
  assign in_ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_a_q <= 1'b0;
    else if (en_a) v_a_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      cmd_a_q <= cmd_e'(cmd_i);
      xr_a_q  <= x_re_i;
      xi_a_q  <= x_im_i;
      yr_a_q  <= y_re_i;
      yi_a_q  <= y_im_i;
      prr_q   <= prr_d;
      pii_q   <= pii_d;
      pri_q   <= pri_d;
      pir_q   <= pir_d;
      pyr_q   <= pyr_d;
      pyi_q   <= pyi_d;
    end
  end

  // stage B: exact sums per operation and the divisor
  logic               v_b_q;
  cmd_e               cmd_b_q;
  logic signed [64:0] sre_d, sim_d, sre_q, sim_q;
  logic [MW-1:0]      den_d, den_q;

  always_comb begin
    sre_d = '0;
    sim_d = '0;
    case (cmd_a_q)
      CMD_ADD: begin
        sre_d = xr_a_q + yr_a_q;
        sim_d = xi_a_q + yi_a_q;
      end
      CMD_SUB: begin
        sre_d = xr_a_q - yr_a_q;
        sim_d = xi_a_q - yi_a_q;
      end
      CMD_MUL: begin
        sre_d = prr_q - pii_q;
        sim_d = pri_q + pir_q;
      end
      CMD_DIV: begin
        sre_d = prr_q + pii_q;
        sim_d = pir_q - pri_q;
      end
      CMD_NEG: begin
        sre_d = 65'sd0 - xr_a_q;
        sim_d = 65'sd0 - xi_a_q;
      end
      default: begin
        sre_d = '0;
        sim_d = '0;
      end
    endcase
  end

  assign den_d = $unsigned(pyr_q) + $unsigned(pyi_q);
  assign en_b  = !v_b_q || en_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_b_q <= 1'b0;
    else if (en_b) v_b_q <= v_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      cmd_b_q <= cmd_a_q;
      sre_q   <= sre_d;
      sim_q   <= sim_d;
      den_q   <= den_d;
    end
  end

  // stage C: sign and magnitude, fraction drop for multiply
  logic          v_c_q;
  side_t         side_d, side_c_q;
  logic [MW-1:0] den_c_q;
  logic [64:0]   abs_re, abs_im;

  assign abs_re = sre_q[64] ? 65'(-sre_q) : 65'(sre_q);
  assign abs_im = sim_q[64] ? 65'(-sim_q) : 65'(sim_q);

  always_comb begin
    side_d.is_div = (cmd_b_q == CMD_DIV);
    side_d.dz     = (cmd_b_q == CMD_DIV) && (den_q == '0);
    side_d.neg_re = sre_q[64];
    side_d.neg_im = sim_q[64];
    side_d.mag_re = abs_re[MW-1:0];
    side_d.mag_im = abs_im[MW-1:0];
    if (cmd_b_q == CMD_MUL) begin
      side_d.mag_re = abs_re[MW-1:0] >> FRAC_BITS;
      side_d.mag_im = abs_im[MW-1:0] >> FRAC_BITS;
    end
  end

  assign en_c = !v_c_q || div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_c_q <= 1'b0;
    else if (en_c) v_c_q <= v_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      side_c_q <= side_d;
      den_c_q  <= den_q;
    end
  end

  // divider lanes
  logic              v_dv;
  side_t             side_dv;
  logic [QBITS-1:0]  q_re, q_im;
  logic              big_re, big_im;

  cau_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v_c_q),
    .ready_o  (div_ready),
    .side_i   (side_c_q),
    .den_i    (den_c_q),
    .valid_o  (v_dv),
    .ready_i  (en_o),
    .side_o   (side_dv),
    .q_re_o   (q_re),
    .q_im_o   (q_im),
    .big_re_o (big_re),
    .big_im_o (big_im)
  );

  // output stage: pick magnitude, saturate, register
  logic [MW-1:0] fm_re, fm_im;
  logic [32:0]   sat_re, sat_im;
  logic          out_valid_q, ovf_q, dz_q;
  logic [31:0]   res_re_q, res_im_q;

  always_comb begin
    fm_re = side_dv.mag_re;
    fm_im = side_dv.mag_im;
    if (side_dv.is_div) begin
      fm_re = big_re ? MW'(64'h2_0000_0000) : MW'(q_re);
      fm_im = big_im ? MW'(64'h2_0000_0000) : MW'(q_im);
    end
  end

  assign sat_re = sat_fn(side_dv.neg_re, fm_re);
  assign sat_im = sat_fn(side_dv.neg_im, fm_im);
  assign en_o   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en_o) out_valid_q <= v_dv;
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      if (side_dv.dz) begin
        res_re_q <= '0;
        res_im_q <= '0;
        ovf_q    <= 1'b0;
        dz_q     <= 1'b1;
      end else begin
        res_re_q <= sat_re[31:0];
        res_im_q <= sat_im[31:0];
        ovf_q    <= sat_re[32] | sat_im[32];
        dz_q     <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign overflow_o  = ovf_q;
  assign div_zero_o  = dz_q;

  // checks
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> res_re_o == '0 && res_im_o == '0 && !overflow_o)
    else $error("divide by zero item carries a non-zero result");

  a_ovf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      res_re_o == 32'sh7FFF_FFFF || res_re_o == 32'sh8000_0000 ||
      res_im_o == 32'sh7FFF_FFFF || res_im_o == 32'sh8000_0000)
    else $error("overflow flagged without a saturated part");

  a_take_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_a_q |-> in_ready_o)
    else $error("input held off while first stage is empty");

endmodule

>>> test/complex_arithmetic_unit_tb.sv
// Self-checking testbench for complex_arithmetic_unit: directed and random items,
// with per-result prediction and random stalls on both sides.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = 38;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } cplx_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         cmd_i = '0;
  logic signed [31:0] x_re_i = '0;
  logic signed [31:0] x_im_i = '0;
  logic signed [31:0] y_re_i = '0;
  logic signed [31:0] y_im_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] res_re_o;
  logic signed [31:0] res_im_o;
  logic               overflow_o;
  logic               div_zero_o;

  cplx_res_t   pending_q[$];
  int unsigned n_errors = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  int unsigned recv_hold = 0;

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (.*);

  // clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // saturate one exact part to 32 bits; bit 32 of the return flags overflow
  function automatic logic [32:0] sat_part(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < -128'sh8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // drop fraction bits, rounding toward zero
  function automatic logic signed [127:0] trunc_frac(input logic signed [127:0] v);
    if (v < 0) return -((-v) >>> FRAC);
    return v >>> FRAC;
  endfunction

  // exact quotient n * 2^FRAC / den, truncated toward zero
  function automatic logic signed [127:0] frac_quot(input logic signed [127:0] n,
                                                    input logic [127:0] den);
    logic [127:0] m;
    m = (n < 0) ? -n : n;
    m = (m << FRAC) / den;
    return (n < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic cplx_res_t predict_result(input logic [2:0] cmd,
      input logic signed [31:0] xr, input logic signed [31:0] xi,
      input logic signed [31:0] yr, input logic signed [31:0] yi);
    logic signed [127:0] a, b, c, d, re_v, im_v;
    logic [127:0] den;
    logic [32:0] sr, si;
    cplx_res_t r;
    a = xr; b = xi; c = yr; d = yi;
    re_v = 0; im_v = 0;
    r = '{re: '0, im: '0, ovf: 1'b0, dz: 1'b0};
    case (cmd)
      CMD_ADD: begin re_v = a + c; im_v = b + d; end
      CMD_SUB: begin re_v = a - c; im_v = b - d; end
      CMD_MUL: begin
        re_v = trunc_frac(a * c - b * d);
        im_v = trunc_frac(a * d + b * c);
      end
      CMD_DIV: begin
        den = c * c + d * d;
        if (den == 0) r.dz = 1'b1;
        else begin
          re_v = frac_quot(a * c + b * d, den);
          im_v = frac_quot(b * c - a * d, den);
        end
      end
      CMD_NEG: begin re_v = -a; im_v = -b; end
      default: ;
    endcase
    sr = sat_part(re_v);
    si = sat_part(im_v);
    r.re = sr[31:0];
    r.im = si[31:0];
    r.ovf = sr[32] | si[32];
    return r;
  endfunction

  // offer one item, wait for acceptance, then record its prediction
  task automatic send_item(input logic [2:0] cmd, input logic [31:0] xr,
      input logic [31:0] xi, input logic [31:0] yr, input logic [31:0] yi);
    int gap;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd; x_re_i <= xr; x_im_i <= xi; y_re_i <= yr; y_im_i <= yi;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(predict_result(cmd, xr, xi, yr, yi));
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // operand part: extremes, small values or full-range noise
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      5: return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_cmd();
    return ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
  endfunction

  // receiver: stall per item, or a long hold when asked
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (recv_hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (recv_hold) @(posedge clk_i);
        recv_hold = 0;
      end else begin
        gap = recv_gaps ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    cplx_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: re %h im %h", $time,
                 res_re_o, res_im_o);
        n_errors++;
      end else begin
        e = pending_q.pop_front();
        if (res_re_o !== e.re) begin
          $display("%0t: res_re expected %h actual %h", $time, e.re, res_re_o);
          n_errors++;
        end
        if (res_im_o !== e.im) begin
          $display("%0t: res_im expected %h actual %h", $time, e.im, res_im_o);
          n_errors++;
        end
        if (overflow_o !== e.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, e.ovf, overflow_o);
          n_errors++;
        end
        if (div_zero_o !== e.dz) begin
          $display("%0t: div_zero expected %b actual %b", $time, e.dz, div_zero_o);
          n_errors++;
        end
      end
    end
  end

  // extremes, each operation, saturation, divide by zero, undefined codes
  task automatic test_directed();
    send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
    send_item(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(CMD_SUB, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
    send_item(CMD_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    send_item(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_item(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0000);
    send_item(CMD_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
    send_item(CMD_DIV, 32'hFFFF_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(CMD_DIV, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    send_item(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1111_1111, 32'h2222_2222);
    send_item(CMD_NEG, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_item(3'd5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    go_idle();
  endtask

  // random items in stretches, with and without stalls
  task automatic test_random(input int n_items);
    logic [31:0] yr, yi;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        send_gaps = $urandom_range(0, 2) != 0;
        recv_gaps = $urandom_range(0, 2) != 0;
      end
      yr = rand_part();
      yi = ($urandom_range(0, 3) == 0) ? 32'h0 : rand_part();
      send_item(rand_cmd(), rand_part(), rand_part(), yr, yi);
    end
    go_idle();
  endtask

  // long receiver hold while the sender keeps offering, so the pipe fills
  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_hold = 150;
    for (int i = 0; i < 80; i++)
      send_item(rand_cmd(), rand_part(), rand_part(), rand_part(), rand_part());
    go_idle();
    send_gaps = 1'b1;
  endtask

  // sender pauses until the pipe is empty, then resumes
  task automatic test_drain_pause();
    wait (pending_q.size() == 0);
    repeat (3)
      send_item(CMD_DIV, rand_part(), rand_part(), rand_part(), rand_part());
    go_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    test_backpressure();
    test_drain_pause();
    test_random(650);
    wait (pending_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && pending_q.size() == 0)
      $display("** complex_arithmetic_unit: PASSED **");
    else
      $display("** complex_arithmetic_unit: FAILED **");
    $finish;
  end

  // timeout
  initial begin
    #2_000_000;
    $display("** complex_arithmetic_unit: FAILED **");
    $finish;
  end

endmodule
